// File: hw/rtl/lpsc_pkg.sv
// ----------------------------------------------------------------------------
// Light panel state controller package
// Shared widths, codes, item layouts and the range clamp.
// ----------------------------------------------------------------------------
package lpsc_pkg;

   localparam int SWITCH_COUNT = 6;
   localparam int MASK_W       = 6;
   localparam int SW_IDX_W     = 3;
   localparam logic [MASK_W-1:0] ALL_SW = MASK_W'((1 << SWITCH_COUNT) - 1);

   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 32;
   localparam int RSP_USER_W = 2;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [2:0] {
      FUNC_BUTTON        = 3'd0,
      FUNC_CW            = 3'd1,
      FUNC_CCW           = 3'd2,
      FUNC_REMOTE_SWITCH = 3'd3,
      FUNC_REMOTE_ONOFF  = 3'd4,
      FUNC_REMOTE_BRIGHT = 3'd5,
      FUNC_REMOTE_TEMP   = 3'd6,
      FUNC_REMOTE_SERIAL = 3'd7
   } func_type;

   typedef enum logic [2:0] {
      CSR_BRIGHT_MIN  = 3'd0,
      CSR_BRIGHT_MAX  = 3'd1,
      CSR_TEMP_MIN    = 3'd2,
      CSR_TEMP_MAX    = 3'd3,
      CSR_VFAST_WIN   = 3'd4,
      CSR_FAST_WIN    = 3'd5,
      CSR_MEDIUM_WIN  = 3'd6
   } csr_index_type;

   localparam logic [7:0] BTN_ALL_OFF = 8'd7;
   localparam logic [7:0] BTN_MODE    = 8'd8;

   localparam logic [8:0] BRIGHT_STEP_SLOW   = 9'd1;
   localparam logic [8:0] BRIGHT_STEP_MEDIUM = 9'd2;
   localparam logic [8:0] BRIGHT_STEP_FAST   = 9'd5;
   localparam logic [8:0] BRIGHT_STEP_VFAST  = 9'd10;
   localparam logic [8:0] TEMP_STEP_SLOW     = 9'd100;
   localparam logic [8:0] TEMP_STEP_MEDIUM   = 9'd200;
   localparam logic [8:0] TEMP_STEP_FAST     = 9'd300;
   localparam logic [8:0] TEMP_STEP_VFAST    = 9'd500;

   localparam logic [7:0]  RST_BRIGHT_MIN = 8'd1;
   localparam logic [7:0]  RST_BRIGHT_MAX = 8'd100;
   localparam logic [15:0] RST_TEMP_MIN   = 16'd2700;
   localparam logic [15:0] RST_TEMP_MAX   = 16'd6500;
   localparam logic [15:0] RST_VFAST_WIN  = 16'd60;
   localparam logic [15:0] RST_FAST_WIN   = 16'd130;
   localparam logic [15:0] RST_MEDIUM_WIN = 16'd300;
   localparam logic [7:0]  RST_BRIGHTNESS = 8'd100;
   localparam logic [15:0] RST_KELVIN     = 16'd4000;

   typedef struct packed {
      logic [31:0] event_time;
      logic [15:0] set_value;
      logic [7:0]  input_number;
      func_type    func;
   } req_item_type;

   typedef struct packed {
      logic              temp_mode;
      logic              serial_on;
      logic [15:0]       white_kelvin;
      logic [7:0]        brightness_level;
      logic [MASK_W-1:0] switch_mask;
   } rsp_item_type;

   typedef struct packed {
      logic from_remote;
      logic changed;
   } rsp_flags_type;

   function automatic logic [15:0] clamp_value(input logic signed [17:0] v,
                                               input logic [15:0] lo,
                                               input logic [15:0] hi);
      logic signed [17:0] lo_s;
      logic signed [17:0] hi_s;
      logic [15:0]        r;
      lo_s = $signed({2'b00, lo});
      hi_s = $signed({2'b00, hi});
      if (v < lo_s) begin
         r = lo;
      end else if (v > hi_s) begin
         r = hi;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

endpackage

// File: hw/rtl/light_panel_state_controller_top.sv
// ----------------------------------------------------------------------------
// Light panel state controller
// Switch mask, brightness, white temperature, serial flag and encoder mode,
// driven by panel buttons, encoder rotation and remote commands.
//
// Usage:
//   req_*  : one event per item (func, input_number, set_value, event_time).
//   rsp_*  : one result per event, the state after it plus changed and
//            from_remote flags in rsp_tuser.
//   csr_*  : APB-style register port, seven registers at byte address 4*i,
//            pready tied high, reads return the register value.
// An accepted item lands in the input register, then fires into the state
// and result registers, which raise rsp_tvalid. Throughput is one item per
// cycle while results are taken; the state read-modify-write is
// combinational, so back-to-back events see each other's effect.
// Reset clears both item stages and loads the default state and registers.
// While rsp_tready is low the result holds, one more item may wait in the
// input register, and req_tready then drops until the result is taken.
// ----------------------------------------------------------------------------
module light_panel_state_controller_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // func[2:0], input_number[10:3], set_value[26:11], event_time[58:27]
   input  logic [lpsc_pkg::REQ_DATA_W-1:0]    req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // switch_mask[5:0], brightness_level[13:6], white_kelvin[29:14],
   // serial_on[30], temp_mode[31]
   output logic [lpsc_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // changed[0], from_remote[1]
   output logic [lpsc_pkg::RSP_USER_W-1:0]    rsp_tuser,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [lpsc_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [lpsc_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [lpsc_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                               csr_pready
);

   logic [7:0]  bright_min_ff;
   logic [7:0]  bright_max_ff;
   logic [15:0] temp_min_ff;
   logic [15:0] temp_max_ff;
   logic [15:0] vfast_win_ff;
   logic [15:0] fast_win_ff;
   logic [15:0] medium_win_ff;

   logic                        csr_write;
   lpsc_pkg::csr_index_type     csr_index;

   logic                        in_valid_ff;
   logic                        in_valid_in;
   lpsc_pkg::req_item_type      in_item_ff;
   logic                        rsp_valid_ff;
   logic                        rsp_valid_in;
   lpsc_pkg::rsp_item_type      rsp_item_ff;
   lpsc_pkg::rsp_flags_type     rsp_flags_ff;
   logic                        advance;
   logic                        fire;

   logic [lpsc_pkg::MASK_W-1:0] switches_ff;
   logic [lpsc_pkg::MASK_W-1:0] switches_in;
   logic [lpsc_pkg::MASK_W-1:0] last_mask_ff;
   logic [lpsc_pkg::MASK_W-1:0] last_mask_in;
   logic [7:0]                  bright_ff;
   logic [7:0]                  bright_in;
   logic [15:0]                 kelvin_ff;
   logic [15:0]                 kelvin_in;
   logic                        serial_ff;
   logic                        serial_in;
   logic                        mode_ff;
   logic                        mode_in;
   logic [31:0]                 last_step_ff;
   logic [31:0]                 last_step_in;
   logic                        dirty;

   // ---------------------------------------------------------------- CSR
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = lpsc_pkg::csr_index_type'(csr_paddr[4:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         bright_min_ff <= lpsc_pkg::RST_BRIGHT_MIN;
         bright_max_ff <= lpsc_pkg::RST_BRIGHT_MAX;
         temp_min_ff   <= lpsc_pkg::RST_TEMP_MIN;
         temp_max_ff   <= lpsc_pkg::RST_TEMP_MAX;
         vfast_win_ff  <= lpsc_pkg::RST_VFAST_WIN;
         fast_win_ff   <= lpsc_pkg::RST_FAST_WIN;
         medium_win_ff <= lpsc_pkg::RST_MEDIUM_WIN;
      end else if (csr_write) begin
         unique case (csr_index)
            lpsc_pkg::CSR_BRIGHT_MIN: bright_min_ff <= csr_pwdata[7:0];
            lpsc_pkg::CSR_BRIGHT_MAX: bright_max_ff <= csr_pwdata[7:0];
            lpsc_pkg::CSR_TEMP_MIN:   temp_min_ff   <= csr_pwdata[15:0];
            lpsc_pkg::CSR_TEMP_MAX:   temp_max_ff   <= csr_pwdata[15:0];
            lpsc_pkg::CSR_VFAST_WIN:  vfast_win_ff  <= csr_pwdata[15:0];
            lpsc_pkg::CSR_FAST_WIN:   fast_win_ff   <= csr_pwdata[15:0];
            lpsc_pkg::CSR_MEDIUM_WIN: medium_win_ff <= csr_pwdata[15:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         lpsc_pkg::CSR_BRIGHT_MIN: csr_prdata = {24'd0, bright_min_ff};
         lpsc_pkg::CSR_BRIGHT_MAX: csr_prdata = {24'd0, bright_max_ff};
         lpsc_pkg::CSR_TEMP_MIN:   csr_prdata = {16'd0, temp_min_ff};
         lpsc_pkg::CSR_TEMP_MAX:   csr_prdata = {16'd0, temp_max_ff};
         lpsc_pkg::CSR_VFAST_WIN:  csr_prdata = {16'd0, vfast_win_ff};
         lpsc_pkg::CSR_FAST_WIN:   csr_prdata = {16'd0, fast_win_ff};
         lpsc_pkg::CSR_MEDIUM_WIN: csr_prdata = {16'd0, medium_win_ff};
         default:                  csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------- handshake
   assign advance      = !rsp_valid_ff || rsp_tready;
   assign fire         = in_valid_ff && advance;
   assign req_tready   = !in_valid_ff || advance;
   assign in_valid_in  = req_tready ? req_tvalid : in_valid_ff;
   assign rsp_valid_in = fire ? 1'b1 : (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_item_ff <= lpsc_pkg::req_item_type'(req_tdata[58:0]);
      end
   end

   // ------------------------------------------------------- state update
   always_comb begin
      logic [31:0]                 elapsed;
      logic [1:0]                  speed;
      logic [8:0]                  b_step;
      logic [8:0]                  k_step;
      logic signed [17:0]          b_sum;
      logic signed [17:0]          k_sum;
      logic [15:0]                 b_once;
      logic [15:0]                 k_once;
      logic                        num_ok;
      logic [lpsc_pkg::MASK_W-1:0] sw_bit;
      logic [lpsc_pkg::MASK_W-1:0] restore;
      logic                        mask_put;
      logic [lpsc_pkg::MASK_W-1:0] mask_tgt;
      logic                        save_last;
      logic                        mask_chg;
      logic                        b_put;
      logic [7:0]                  b_tgt;
      logic                        k_put;
      logic [15:0]                 k_tgt;
      logic                        b_chg;
      logic                        k_chg;

      elapsed = in_item_ff.event_time - last_step_ff;
      priority if (elapsed <= {16'd0, vfast_win_ff}) begin
         speed = 2'd3;
      end else if (elapsed <= {16'd0, fast_win_ff}) begin
         speed = 2'd2;
      end else if (elapsed <= {16'd0, medium_win_ff}) begin
         speed = 2'd1;
      end else begin
         speed = 2'd0;
      end
      unique case (speed)
         2'd3: begin
            b_step = lpsc_pkg::BRIGHT_STEP_VFAST;
            k_step = lpsc_pkg::TEMP_STEP_VFAST;
         end
         2'd2: begin
            b_step = lpsc_pkg::BRIGHT_STEP_FAST;
            k_step = lpsc_pkg::TEMP_STEP_FAST;
         end
         2'd1: begin
            b_step = lpsc_pkg::BRIGHT_STEP_MEDIUM;
            k_step = lpsc_pkg::TEMP_STEP_MEDIUM;
         end
         default: begin
            b_step = lpsc_pkg::BRIGHT_STEP_SLOW;
            k_step = lpsc_pkg::TEMP_STEP_SLOW;
         end
      endcase

      if (in_item_ff.func == lpsc_pkg::FUNC_CCW) begin
         b_sum = $signed({10'd0, bright_ff}) - $signed({9'd0, b_step});
         k_sum = $signed({2'd0, kelvin_ff}) - $signed({9'd0, k_step});
      end else begin
         b_sum = $signed({10'd0, bright_ff}) + $signed({9'd0, b_step});
         k_sum = $signed({2'd0, kelvin_ff}) + $signed({9'd0, k_step});
      end
      b_once = lpsc_pkg::clamp_value(b_sum, {8'd0, bright_min_ff}, {8'd0, bright_max_ff});
      k_once = lpsc_pkg::clamp_value(k_sum, temp_min_ff, temp_max_ff);

      num_ok = (in_item_ff.input_number >= 8'd1)
            && (in_item_ff.input_number <= 8'(lpsc_pkg::SWITCH_COUNT));
      sw_bit = lpsc_pkg::MASK_W'(1)
               << lpsc_pkg::SW_IDX_W'(in_item_ff.input_number - 8'd1);
      restore = last_mask_ff & lpsc_pkg::ALL_SW;
      if (restore == '0) begin
         restore = lpsc_pkg::ALL_SW;
      end

      mask_put     = 1'b0;
      mask_tgt     = switches_ff;
      save_last    = 1'b0;
      b_put        = 1'b0;
      b_tgt        = bright_ff;
      k_put        = 1'b0;
      k_tgt        = kelvin_ff;
      mode_in      = mode_ff;
      serial_in    = serial_ff;
      last_step_in = last_step_ff;

      unique case (in_item_ff.func)
         lpsc_pkg::FUNC_BUTTON: begin
            priority if (num_ok) begin
               mask_put = 1'b1;
               mask_tgt = switches_ff ^ sw_bit;
            end else if (in_item_ff.input_number == lpsc_pkg::BTN_ALL_OFF) begin
               mask_put = 1'b1;
               if (switches_ff != '0) begin
                  save_last = 1'b1;
                  mask_tgt  = '0;
               end else begin
                  mask_tgt = restore;
               end
            end else if (in_item_ff.input_number == lpsc_pkg::BTN_MODE) begin
               mode_in = !mode_ff;
            end else begin
            end
         end
         lpsc_pkg::FUNC_CW, lpsc_pkg::FUNC_CCW: begin
            last_step_in = in_item_ff.event_time;
            if (!mode_ff) begin
               b_put = 1'b1;
               b_tgt = 8'(lpsc_pkg::clamp_value($signed({2'd0, b_once}),
                  {8'd0, bright_min_ff}, {8'd0, bright_max_ff}));
            end else begin
               k_put = 1'b1;
               k_tgt = lpsc_pkg::clamp_value($signed({2'd0, k_once}),
                  temp_min_ff, temp_max_ff);
            end
         end
         lpsc_pkg::FUNC_REMOTE_SWITCH: begin
            if (in_item_ff.input_number == 8'd0) begin
               mask_put = 1'b1;
               mask_tgt = in_item_ff.set_value[lpsc_pkg::MASK_W-1:0] & lpsc_pkg::ALL_SW;
            end else if (num_ok) begin
               mask_put = 1'b1;
               mask_tgt = (in_item_ff.set_value != '0) ? (switches_ff | sw_bit)
                                                       : (switches_ff & ~sw_bit);
            end
         end
         lpsc_pkg::FUNC_REMOTE_ONOFF: begin
            mask_put = 1'b1;
            if (in_item_ff.set_value != '0) begin
               mask_tgt = restore;
            end else begin
               save_last = (switches_ff != '0);
               mask_tgt  = '0;
            end
         end
         lpsc_pkg::FUNC_REMOTE_BRIGHT: begin
            b_put = 1'b1;
            b_tgt = 8'(lpsc_pkg::clamp_value($signed({10'd0, in_item_ff.set_value[7:0]}),
               {8'd0, bright_min_ff}, {8'd0, bright_max_ff}));
         end
         lpsc_pkg::FUNC_REMOTE_TEMP: begin
            k_put = 1'b1;
            k_tgt = lpsc_pkg::clamp_value($signed({2'd0, in_item_ff.set_value}),
               temp_min_ff, temp_max_ff);
         end
         lpsc_pkg::FUNC_REMOTE_SERIAL: begin
            serial_in = (in_item_ff.set_value != '0);
         end
         default: begin
         end
      endcase

      mask_chg    = mask_put && (mask_tgt != switches_ff);
      switches_in = mask_chg ? mask_tgt : switches_ff;
      if (mask_chg && (mask_tgt != '0)) begin
         last_mask_in = mask_tgt;
      end else if (save_last) begin
         last_mask_in = switches_ff & lpsc_pkg::ALL_SW;
      end else begin
         last_mask_in = last_mask_ff;
      end
      b_chg     = b_put && (b_tgt != bright_ff);
      k_chg     = k_put && (k_tgt != kelvin_ff);
      bright_in = b_chg ? b_tgt : bright_ff;
      kelvin_in = k_chg ? k_tgt : kelvin_ff;
      dirty     = mask_chg || b_chg || k_chg || (serial_in != serial_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         switches_ff  <= '0;
         last_mask_ff <= lpsc_pkg::ALL_SW;
         bright_ff    <= lpsc_pkg::RST_BRIGHTNESS;
         kelvin_ff    <= lpsc_pkg::RST_KELVIN;
         serial_ff    <= 1'b0;
         mode_ff      <= 1'b0;
         last_step_ff <= '0;
      end else if (fire) begin
         switches_ff  <= switches_in;
         last_mask_ff <= last_mask_in;
         bright_ff    <= bright_in;
         kelvin_ff    <= kelvin_in;
         serial_ff    <= serial_in;
         mode_ff      <= mode_in;
         last_step_ff <= last_step_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_item_ff.switch_mask      <= switches_in;
         rsp_item_ff.brightness_level <= bright_in;
         rsp_item_ff.white_kelvin     <= kelvin_in;
         rsp_item_ff.serial_on        <= serial_in;
         rsp_item_ff.temp_mode        <= mode_in;
         rsp_flags_ff.changed         <= dirty;
         rsp_flags_ff.from_remote     <= (in_item_ff.func >= lpsc_pkg::FUNC_REMOTE_SWITCH);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_item_ff;
   assign rsp_tuser  = rsp_flags_ff;

endmodule

// File: hw/rtl/lpsc_checker.sv
// ----------------------------------------------------------------------------
// Light panel state controller port checker
// Port-level properties of the result channel and its back-pressure.
// ----------------------------------------------------------------------------
module lpsc_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic [lpsc_pkg::REQ_DATA_W-1:0] req_tdata,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [lpsc_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [lpsc_pkg::RSP_USER_W-1:0] rsp_tuser
);

   // drop any result after reset
   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid straight after reset");

   // hold a stalled result
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // stall the input only behind a waiting result
   a_stall_cause : assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !$past(reset))
      else $error("input stalled with no result waiting");

   // advance an accepted item from the input register to the result register when no result is waiting
   a_accept_flow : assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !rsp_tvalid ##1 !reset |=> rsp_tvalid)
      else $error("accepted item never reached the result register");

endmodule

bind light_panel_state_controller_top lpsc_checker u_lpsc_checker (.*);

// File: tb/sv/tb_light_panel_state_controller_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Light panel state controller testbench
// Sends panel, encoder and remote events through the request stream and
// checks every result against a predictor of the panel state. Covers button
// toggles, all-off and restore, mode flips, timed encoder steps with
// clamping, remote commands, inverted and extreme register settings,
// backpressure and random traffic under several idling patterns.
// ----------------------------------------------------------------------------
module tb_light_panel_state_controller_top;
   import lpsc_pkg::*;

   typedef struct packed {
      rsp_item_type  state;
      rsp_flags_type flags;
   } panel_result_type;

   typedef struct packed {
      logic [7:0]  bright_min;
      logic [7:0]  bright_max;
      logic [15:0] temp_min;
      logic [15:0] temp_max;
      logic [15:0] vfast_win;
      logic [15:0] fast_win;
      logic [15:0] medium_win;
   } panel_settings_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   light_panel_state_controller_top DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #10 clock = ~clock;

   panel_settings_type    cfg;
   logic [MASK_W-1:0]     sw_mask;
   logic [MASK_W-1:0]     memo_mask;
   logic [7:0]            brightness;
   logic [15:0]           kelvin;
   logic                  serial_en;
   logic                  temp_mode;
   logic [31:0]           last_step_tick;
   logic                  touched;

   panel_result_type      pending_results[$];
   int                    failures;
   int                    send_gap_pct;
   int                    stall_pct;
   int                    hold_cycles;
   logic [31:0]           tick_now;

   function automatic int clamp_int(int v, int lo, int hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic void load_mask(logic [7:0] m);
      logic [MASK_W-1:0] nxt;
      nxt = m[MASK_W-1:0] & ALL_SW;
      if (nxt == sw_mask) return;
      sw_mask = nxt;
      if (nxt != 0) memo_mask = nxt;
      touched = 1'b1;
   endfunction

   function automatic void set_switch(int id, logic on);
      logic [MASK_W-1:0] bit_v;
      if (id < 1 || id > SWITCH_COUNT) return;
      bit_v = MASK_W'(1 << (id - 1));
      load_mask(8'(on ? (sw_mask | bit_v) : (sw_mask & ~bit_v)));
   endfunction

   function automatic void switches_off();
      if (sw_mask != 0) memo_mask = sw_mask;
      load_mask(8'd0);
   endfunction

   function automatic void restore_mask();
      logic [MASK_W-1:0] r;
      r = memo_mask;
      if (r == 0) r = ALL_SW;
      load_mask(8'(r));
   endfunction

   function automatic void set_brightness(int v);
      int nxt;
      nxt = clamp_int(v, cfg.bright_min, cfg.bright_max);
      if (nxt == brightness) return;
      brightness = 8'(nxt);
      touched = 1'b1;
   endfunction

   function automatic void set_kelvin(int v);
      int nxt;
      nxt = clamp_int(v, cfg.temp_min, cfg.temp_max);
      if (nxt == kelvin) return;
      kelvin = 16'(nxt);
      touched = 1'b1;
   endfunction

   function automatic int step_for(logic [31:0] t, int s0, int s1, int s2, int s3);
      logic [31:0] elapsed;
      elapsed = t - last_step_tick;
      last_step_tick = t;
      if (elapsed <= {16'd0, cfg.vfast_win}) return s3;
      if (elapsed <= {16'd0, cfg.fast_win}) return s2;
      if (elapsed <= {16'd0, cfg.medium_win}) return s1;
      return s0;
   endfunction

   // clamp twice: an inverted range gives a different value the second time
   function automatic void turn_encoder(int dir, logic [31:0] t);
      int step;
      if (!temp_mode) begin
         step = step_for(t, BRIGHT_STEP_SLOW, BRIGHT_STEP_MEDIUM, BRIGHT_STEP_FAST,
                         BRIGHT_STEP_VFAST);
         set_brightness(clamp_int(int'(brightness) + dir * step, cfg.bright_min,
                                  cfg.bright_max));
      end else begin
         step = step_for(t, TEMP_STEP_SLOW, TEMP_STEP_MEDIUM, TEMP_STEP_FAST,
                         TEMP_STEP_VFAST);
         set_kelvin(clamp_int(int'(kelvin) + dir * step, cfg.temp_min, cfg.temp_max));
      end
   endfunction

   function automatic panel_result_type predict_panel_state(req_item_type ev);
      panel_result_type e;
      touched = 1'b0;
      case (ev.func)
         FUNC_BUTTON: begin
            if (ev.input_number >= 1 && ev.input_number <= SWITCH_COUNT) begin
               set_switch(ev.input_number, ~sw_mask[ev.input_number - 1]);
            end else if (ev.input_number == BTN_ALL_OFF) begin
               if (sw_mask != 0) switches_off();
               else restore_mask();
            end else if (ev.input_number == BTN_MODE) begin
               temp_mode = ~temp_mode;
            end
         end
         FUNC_CW:  turn_encoder(1, ev.event_time);
         FUNC_CCW: turn_encoder(-1, ev.event_time);
         FUNC_REMOTE_SWITCH: begin
            if (ev.input_number == 0) load_mask(ev.set_value[7:0]);
            else set_switch(ev.input_number, ev.set_value != 0);
         end
         FUNC_REMOTE_ONOFF: begin
            if (ev.set_value != 0) restore_mask();
            else switches_off();
         end
         FUNC_REMOTE_BRIGHT: set_brightness(ev.set_value[7:0]);
         FUNC_REMOTE_TEMP:   set_kelvin(ev.set_value);
         FUNC_REMOTE_SERIAL: begin
            if ((ev.set_value != 0) != serial_en) begin
               serial_en = ~serial_en;
               touched = 1'b1;
            end
         end
      endcase
      e.state.switch_mask      = sw_mask;
      e.state.brightness_level = brightness;
      e.state.white_kelvin     = kelvin;
      e.state.serial_on        = serial_en;
      e.state.temp_mode        = temp_mode;
      e.flags.changed          = touched;
      e.flags.from_remote      = ev.func >= FUNC_REMOTE_SWITCH;
      return e;
   endfunction

   function automatic req_item_type make_event(func_type f, logic [7:0] num,
                                               logic [15:0] val, logic [31:0] t);
      req_item_type ev;
      ev.func = f;
      ev.input_number = num;
      ev.set_value = val;
      ev.event_time = t;
      return ev;
   endfunction

   function automatic req_item_type random_event();
      req_item_type ev;
      int unsigned  pick;
      pick = $urandom_range(99, 0);
      if (pick < 35) ev.func = ($urandom_range(1, 0) != 0) ? FUNC_CW : FUNC_CCW;
      else if (pick < 60) ev.func = FUNC_BUTTON;
      else ev.func = func_type'(3'($urandom_range(7, 3)));
      pick = $urandom_range(99, 0);
      if (pick < 10) ev.input_number = 8'($urandom_range(255, 0));
      else ev.input_number = 8'($urandom_range(8, 0));
      case ($urandom_range(5, 0))
         0: ev.set_value = 16'd0;
         1: ev.set_value = 16'd1;
         2: ev.set_value = 16'($urandom_range(255, 0));
         3: ev.set_value = 16'($urandom_range(9000, 1000));
         default: ev.set_value = 16'($urandom_range(65535, 0));
      endcase
      case ($urandom_range(9, 0))
         0, 1, 2: tick_now = tick_now + $urandom_range(80, 0);
         3, 4:    tick_now = tick_now + $urandom_range(200, 40);
         5, 6:    tick_now = tick_now + $urandom_range(500, 100);
         7, 8:    tick_now = tick_now + $urandom_range(5000, 300);
         default: tick_now = $urandom();
      endcase
      ev.event_time = tick_now;
      return ev;
   endfunction

   task automatic send_event(input req_item_type ev);
      while ($urandom_range(99, 0) < send_gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= REQ_DATA_W'(ev);
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_results.push_back(predict_panel_state(ev));
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [15:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      case (idx)
         CSR_BRIGHT_MIN: cfg.bright_min = value[7:0];
         CSR_BRIGHT_MAX: cfg.bright_max = value[7:0];
         CSR_TEMP_MIN:   cfg.temp_min = value;
         CSR_TEMP_MAX:   cfg.temp_max = value;
         CSR_VFAST_WIN:  cfg.vfast_win = value;
         CSR_FAST_WIN:   cfg.fast_win = value;
         CSR_MEDIUM_WIN: cfg.medium_win = value;
         default: begin
         end
      endcase
   endtask

   task automatic apply_settings(input panel_settings_type s);
      write_reg(CSR_BRIGHT_MIN, 16'(s.bright_min));
      write_reg(CSR_BRIGHT_MAX, 16'(s.bright_max));
      write_reg(CSR_TEMP_MIN, s.temp_min);
      write_reg(CSR_TEMP_MAX, s.temp_max);
      write_reg(CSR_VFAST_WIN, s.vfast_win);
      write_reg(CSR_FAST_WIN, s.fast_win);
      write_reg(CSR_MEDIUM_WIN, s.medium_win);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic set_idling(input int gap, input int stall);
      send_gap_pct = gap;
      stall_pct = stall;
   endtask

   task automatic test_buttons();
      send_event(make_event(FUNC_BUTTON, 8'd1, 16'd0, 32'd0));
      send_event(make_event(FUNC_BUTTON, 8'd3, 16'd0, 32'd0));
      send_event(make_event(FUNC_BUTTON, 8'd6, 16'd0, 32'd0));
      send_event(make_event(FUNC_BUTTON, BTN_ALL_OFF, 16'd0, 32'd0));
      send_event(make_event(FUNC_BUTTON, BTN_ALL_OFF, 16'd0, 32'd0));
      send_event(make_event(FUNC_BUTTON, 8'd0, 16'hFFFF, 32'd0));
      send_event(make_event(FUNC_BUTTON, 8'd255, 16'hFFFF, 32'd0));
      send_event(make_event(FUNC_BUTTON, BTN_MODE, 16'd0, 32'd0));
   endtask

   task automatic test_encoder_steps();
      send_event(make_event(FUNC_CW, 8'd0, 16'd0, 32'd40));
      send_event(make_event(FUNC_CW, 8'd0, 16'd0, 32'd150));
      send_event(make_event(FUNC_CCW, 8'd0, 16'd0, 32'd400));
      send_event(make_event(FUNC_CCW, 8'd0, 16'd0, 32'd2000));
      send_event(make_event(FUNC_BUTTON, BTN_MODE, 16'd0, 32'd0));
      send_event(make_event(FUNC_CCW, 8'd0, 16'd0, 32'hFFFF_FFF0));
      send_event(make_event(FUNC_CW, 8'd0, 16'd0, 32'h0000_0020));
      send_event(make_event(FUNC_CW, 8'd0, 16'd0, 32'h0000_0020));
   endtask

   task automatic test_remote_commands();
      send_event(make_event(FUNC_REMOTE_SWITCH, 8'd0, 16'hFFFF, 32'd0));
      send_event(make_event(FUNC_REMOTE_SWITCH, 8'd3, 16'd0, 32'd0));
      send_event(make_event(FUNC_REMOTE_SWITCH, 8'd7, 16'd1, 32'd0));
      send_event(make_event(FUNC_REMOTE_ONOFF, 8'd0, 16'd0, 32'd0));
      send_event(make_event(FUNC_REMOTE_ONOFF, 8'd0, 16'h8000, 32'd0));
      send_event(make_event(FUNC_REMOTE_BRIGHT, 8'd0, 16'hFF00, 32'd0));
      send_event(make_event(FUNC_REMOTE_TEMP, 8'd0, 16'hFFFF, 32'd0));
      send_event(make_event(FUNC_REMOTE_SERIAL, 8'd0, 16'h8000, 32'd0));
      send_event(make_event(FUNC_REMOTE_SERIAL, 8'd0, 16'd0, 32'd0));
   endtask

   task automatic test_config_extremes();
      panel_settings_type s;
      drain_results();
      s = '{8'd0, 8'd255, 16'd0, 16'hFFFF, 16'd0, 16'd0, 16'd0};
      apply_settings(s);
      send_event(make_event(FUNC_REMOTE_BRIGHT, 8'd0, 16'd0, 32'd0));
      send_event(make_event(FUNC_CCW, 8'd0, 16'd0, 32'd5000));
      send_event(make_event(FUNC_REMOTE_BRIGHT, 8'd0, 16'd255, 32'd0));
      send_event(make_event(FUNC_CW, 8'd0, 16'd0, 32'd5000));
      send_event(make_event(FUNC_REMOTE_TEMP, 8'd0, 16'hFFFF, 32'd0));
      send_event(make_event(FUNC_BUTTON, BTN_MODE, 16'd0, 32'd0));
      send_event(make_event(FUNC_CW, 8'd0, 16'd0, 32'd9000));
      drain_results();
      // inverted ranges, every window at its top
      s = '{8'd200, 8'd50, 16'd60000, 16'd1000, 16'hFFFF, 16'hFFFF, 16'hFFFF};
      apply_settings(s);
      send_event(make_event(FUNC_REMOTE_TEMP, 8'd0, 16'd3000, 32'd0));
      send_event(make_event(FUNC_CCW, 8'd0, 16'd0, 32'd9100));
      send_event(make_event(FUNC_BUTTON, BTN_MODE, 16'd0, 32'd0));
      send_event(make_event(FUNC_REMOTE_BRIGHT, 8'd0, 16'd100, 32'd0));
      send_event(make_event(FUNC_CW, 8'd0, 16'd0, 32'd9200));
      drain_results();
   endtask

   task automatic test_backpressure();
      set_idling(0, 0);
      hold_cycles = 60;
      repeat (24) send_event(random_event());
      drain_results();
   endtask

   task automatic test_random_traffic();
      panel_settings_type s;
      for (int phase = 0; phase < 8; phase++) begin
         drain_results();
         s.bright_min = 8'($urandom_range(40, 0));
         s.bright_max = 8'($urandom_range(255, 30));
         s.temp_min = 16'($urandom_range(5000, 0));
         s.temp_max = 16'($urandom_range(65535, 3000));
         s.vfast_win = 16'($urandom_range(200, 0));
         s.fast_win = 16'(s.vfast_win + $urandom_range(200, 0));
         s.medium_win = 16'(s.fast_win + $urandom_range(400, 0));
         if (phase == 5) begin
            s.bright_min = 8'($urandom());
            s.bright_max = 8'($urandom());
            s.temp_min = 16'($urandom());
            s.temp_max = 16'($urandom());
            s.vfast_win = 16'($urandom());
            s.fast_win = 16'($urandom());
            s.medium_win = 16'($urandom());
         end
         apply_settings(s);
         case (phase % 4)
            0: set_idling(0, 0);
            1: set_idling(63, 0);
            2: set_idling(0, 63);
            default: set_idling(24, 24);
         endcase
         repeat (240) send_event(random_event());
      end
      drain_results();
   endtask

   task automatic compare_field(input string name, input logic [31:0] exp_v,
                                input logic [31:0] act_v);
      if (act_v !== exp_v) begin
         $error("%s expected %0d actual %0d", name, exp_v, act_v);
         failures++;
      end
   endtask

   task automatic check_result(input rsp_item_type got, input rsp_flags_type got_flags);
      panel_result_type e;
      if (pending_results.size() == 0) begin
         $error("result with no event outstanding: tdata %h tuser %h", got, got_flags);
         failures++;
         return;
      end
      e = pending_results.pop_front();
      compare_field("switch_mask", e.state.switch_mask, got.switch_mask);
      compare_field("brightness_level", e.state.brightness_level, got.brightness_level);
      compare_field("white_kelvin", e.state.white_kelvin, got.white_kelvin);
      compare_field("serial_on", e.state.serial_on, got.serial_on);
      compare_field("temp_mode", e.state.temp_mode, got.temp_mode);
      compare_field("changed", e.flags.changed, got_flags.changed);
      compare_field("from_remote", e.flags.from_remote, got_flags.from_remote);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         check_result(rsp_item_type'(rsp_tdata), rsp_flags_type'(rsp_tuser));
      end
      if (hold_cycles > 0) begin
         hold_cycles = hold_cycles - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99, 0) >= stall_pct);
      end
   end

   initial begin
      #20_000_000;
      $display("light_panel_state_controller_top verification failed");
      $finish;
   end

   initial begin
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;
      failures = 0;
      hold_cycles = 0;
      tick_now = 0;
      set_idling(0, 0);
      cfg = '{RST_BRIGHT_MIN, RST_BRIGHT_MAX, RST_TEMP_MIN, RST_TEMP_MAX,
              RST_VFAST_WIN, RST_FAST_WIN, RST_MEDIUM_WIN};
      sw_mask = '0;
      memo_mask = ALL_SW;
      brightness = RST_BRIGHTNESS;
      kelvin = RST_KELVIN;
      serial_en = 1'b0;
      temp_mode = 1'b0;
      last_step_tick = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_buttons();
      test_encoder_steps();
      test_remote_commands();
      test_config_extremes();
      test_backpressure();
      test_random_traffic();
      drain_results();
      if (failures == 0) begin
         $display("light_panel_state_controller_top verification clean");
      end else begin
         $display("light_panel_state_controller_top verification failed");
      end
      $finish;
   end

endmodule
